>>> hw/rtl/dhbw_pkg.sv
// ----------------------------------------------------------------------------
// dhbw_pkg
// Shared constants, command codes and controller/datapath types for the
// device heartbeat watchdog.
// ----------------------------------------------------------------------------
package dhbw_pkg;

    localparam int CHANNELS  = 16;
    localparam int TIME_BITS = 32;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int MASK_W = 16;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic            tick_en;
        logic            stamp_en;
        logic            rd_en;
        logic [CH_W-1:0] addr;
        logic            mask_clr;
        logic            out_load;
    } dp_cmd_t;

endpackage

>>> hw/rtl/dhbw_if.sv
// ----------------------------------------------------------------------------
// dhbw channel interfaces
// Valid/ready channels for commands, offline masks and the timeout register.
// ----------------------------------------------------------------------------
interface dhbw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] channel;

    modport source (output valid, output cmd, output channel, input ready);
    modport sink   (input valid, input cmd, input channel, output ready);
endinterface

interface dhbw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] offline_mask;

    modport source (output valid, output offline_mask, input ready);
    modport sink   (input valid, input offline_mask, output ready);
endinterface

interface dhbw_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] timeout_ticks;

    modport source (output valid, output timeout_ticks, input ready);
    modport sink   (input valid, input timeout_ticks, output ready);
endinterface

>>> hw/rtl/dhbw_ctrl.sv
// ----------------------------------------------------------------------------
// dhbw_ctrl
// Command decode and scan sequencer; owns the result valid flag.
// ----------------------------------------------------------------------------
module dhbw_ctrl
    import dhbw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    input  logic [3:0] in_channel,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    dp_cmd
);

    state_t          state_reg, state_next;
    logic [CH_W-1:0] idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      ch8;
    logic            ch_ok;
    logic            accept;

    assign ch8       = {4'b0, in_channel};
    assign ch_ok     = (ch8 < 8'(CHANNELS));
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dp_cmd         = '0;
        dp_cmd.addr    = ch8[CH_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(in_cmd))
                        CMD_TICK:    dp_cmd.tick_en = 1'b1;
                        CMD_REFRESH: dp_cmd.stamp_en = ch_ok;
                        CMD_CHECK:
                        begin
                            dp_cmd.mask_clr = 1'b1;
                            idx_next        = '0;
                            state_next      = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one stamp read per cycle, compare lands in the cycle after
                dp_cmd.rd_en = 1'b1;
                dp_cmd.addr  = idx_reg;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.out_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/dhbw_dp.sv
// ----------------------------------------------------------------------------
// dhbw_dp
// Time base, per-channel stamp store, elapsed-time compare and mask build.
// ----------------------------------------------------------------------------
module dhbw_dp
    import dhbw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           dp_cmd,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_timeout,
    output logic [MASK_W-1:0] offline_mask
);

    logic [TIME_BITS-1:0] stamp_mem [CHANNELS];
    logic [CHANNELS-1:0]  stamp_vld_reg;

    logic [TIME_BITS-1:0] time_reg;
    logic [31:0]          timeout_reg;
    logic [TIME_BITS-1:0] rd_data_reg;
    logic                 rd_live_reg;
    logic                 cmp_vld_reg;
    logic [CH_W-1:0]      cmp_idx_reg;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic [MASK_W-1:0]    out_mask_reg;

    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] elapsed;
    logic                 over;
    logic [7:0]           idx8;

    // stamp store, no reset; unwritten entries read as zero via valid bits
    always_ff @(posedge clk)
    begin
        if (dp_cmd.stamp_en)
        begin
            stamp_mem[dp_cmd.addr] <= time_reg;
        end
        if (dp_cmd.rd_en)
        begin
            rd_data_reg <= stamp_mem[dp_cmd.addr];
        end
        if (dp_cmd.rd_en)
        begin
            cmp_idx_reg <= dp_cmd.addr;
        end
        if (dp_cmd.out_load)
        begin
            out_mask_reg <= mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_vld_reg <= '0;
            time_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            rd_live_reg   <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (dp_cmd.stamp_en)
            begin
                stamp_vld_reg[dp_cmd.addr] <= 1'b1;
            end
            if (dp_cmd.tick_en)
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_timeout;
            end
            if (dp_cmd.rd_en)
            begin
                rd_live_reg <= stamp_vld_reg[dp_cmd.addr];
            end
            cmp_vld_reg <= dp_cmd.rd_en;
            mask_reg    <= mask_next;
        end
    end

    assign stamp   = rd_live_reg ? rd_data_reg : '0;
    assign elapsed = time_reg - stamp;
    assign over    = CMP_W'(elapsed) > CMP_W'(timeout_reg);
    assign idx8    = 8'(cmp_idx_reg);

    // only the low sixteen channels show up in the mask
    always_comb
    begin
        mask_next = mask_reg;
        if (dp_cmd.mask_clr)
        begin
            mask_next = '0;
        end
        else if (cmp_vld_reg && over)
        begin
            for (int i = 0; i < MASK_W; i++)
            begin
                if (idx8 == 8'(i))
                begin
                    mask_next[i] = 1'b1;
                end
            end
        end
    end

    assign offline_mask = out_mask_reg;

endmodule

>>> hw/rtl/device_heartbeat_watchdog_top.sv
// ----------------------------------------------------------------------------
// device_heartbeat_watchdog_top
// Heartbeat timeout monitor over a tick-counted time base.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : command beats. cmd tick advances the 10 us time base, refresh
//            stamps the named channel with the current time, check scans all
//            channels; the unused code is accepted and dropped.
//   out_ch : one offline_mask beat per check; bit n set when channel n has
//            been silent for more than timeout_ticks.
//   cfg    : timeout_ticks write beats, always ready; write only while idle.
// Timing:
//   Tick and refresh keep the block idle; the next command is taken right after.
//   A check runs a scan between accept and the mask beat: the
//   stamp store has one read port, so the scan reads one channel per cycle.
//   in_ch.ready is low during the scan.
// Reset:
//   Time base and scan mask clear to zero, stamps read zero; timeout 10000.
// Stalls:
//   The mask sits in an output register; commands keep flowing while it
//   waits. A following check finishes its scan and then holds until the
//   earlier mask beat is taken.
// ----------------------------------------------------------------------------
module device_heartbeat_watchdog_top
    import dhbw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dhbw_in_if.sink    in_ch,
    dhbw_out_if.source out_ch,
    dhbw_cfg_if.sink   cfg
);

    dp_cmd_t dp_cmd;

    assign cfg.ready = 1'b1;

    dhbw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_cmd     (in_ch.cmd),
        .in_channel (in_ch.channel),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .dp_cmd     (dp_cmd)
    );

    dhbw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .cfg_we       (cfg.valid),
        .cfg_timeout  (cfg.timeout_ticks),
        .offline_mask (out_ch.offline_mask)
    );

    // a check blocks further commands once accepted
    a_check_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_CHECK) |=> !in_ch.ready)
        else $error("command accepted right after a check");

    // tick and refresh complete in the accept cycle
    a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready &&
         (in_ch.cmd == CMD_TICK || in_ch.cmd == CMD_REFRESH)) |=> in_ch.ready)
        else $error("tick or refresh stalled the command channel");

    // the scan keeps in_ch.ready low after a check is taken
    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_CHECK)
            |-> ##(CHANNELS + 1) !in_ch.ready)
        else $error("check scan ended early");

endmodule
